### rtl/clrm_pkg.sv
// ----------------------------------------------------------------------------
// clrm_pkg: shared types and constants of the circular log ring manager
// Command and status codes, configuration register indexes, request and
// result payloads, and the decoded operation that goes from front to back.
// ----------------------------------------------------------------------------
package clrm_pkg;

    // command codes on the request channel
    localparam logic [2:0] CMD_RESET  = 3'd0;
    localparam logic [2:0] CMD_APPEND = 3'd1;
    localparam logic [2:0] CMD_DRAIN  = 3'd2;
    localparam logic [2:0] CMD_PEEK   = 3'd3;
    localparam logic [2:0] CMD_LOCK   = 3'd4;

    // result status codes
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_BAD_LEN  = 2'd1;
    localparam logic [1:0] STATUS_BUSY     = 2'd2;
    localparam logic [1:0] STATUS_TOO_LONG = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_REGION_BASE = 2'd0;
    localparam logic [1:0] CFG_REGION_LEN  = 2'd1;
    localparam logic [1:0] CFG_BLOCK_SHIFT = 2'd2;

    // configuration reset values
    localparam logic [31:0] REGION_BASE_RST = 32'd0;
    localparam logic [31:0] REGION_LEN_RST  = 32'd65536;
    localparam logic [4:0]  BLOCK_SHIFT_RST = 5'd12;

    // drain chunk size used when the request gives zero
    localparam logic [15:0] DRAIN_DEFAULT = 16'd1024;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [15:0] length;
        logic        first;
        logic        enable;
    } req_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic        is_write;
        logic [31:0] seg_addr;
        logic [15:0] seg_len;
        logic        last;
        logic [31:0] bytes_held;
    } rsp_item_t;

    typedef enum logic [2:0] {
        OP_RESET,
        OP_APPEND,
        OP_DRAIN,
        OP_PEEK,
        OP_LOCK
    } op_kind_t;

    // decoded operation handed from front to back
    typedef struct packed {
        op_kind_t    kind;
        logic [15:0] length;
        logic [15:0] drain_max;
        logic        len_zero;
        logic        first;
        logic        enable;
    } op_item_t;

    typedef enum logic {
        PH_FIRST,
        PH_SECOND
    } phase_t;

endpackage

### rtl/clrm_queue.sv
// ----------------------------------------------------------------------------
// clrm_queue: small register queue
// Holds up to DEPTH entries of any packed type; head entry shown while not
// empty, push and pop may happen in the same cycle.
// ----------------------------------------------------------------------------
module clrm_queue #(
    parameter type T     = logic,
    parameter int  DEPTH = 2
) (
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    output logic full,
    input  T     wdata,
    input  logic pop,
    output logic empty,
    output T     rdata
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    T              mem_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push, do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

### rtl/clrm_front.sv
// ----------------------------------------------------------------------------
// clrm_front: request intake
// Accepts requests, decodes the command, drops unknown codes, resolves the
// drain chunk default and queues the decoded operation for the back end.
// ----------------------------------------------------------------------------
module clrm_front #(
    parameter int CMD_Q_DEPTH = 2
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  clrm_pkg::req_item_t item,
    input  logic                op_pop,
    output logic                op_empty,
    output clrm_pkg::op_item_t  op_head
);

    clrm_pkg::op_item_t op_dec;
    logic               cmd_known;

    // command decode
    always_comb
    begin
        op_dec.length    = item.length;
        op_dec.drain_max = (item.length == '0) ? clrm_pkg::DRAIN_DEFAULT : item.length;
        op_dec.len_zero  = (item.length == '0);
        op_dec.first     = item.first;
        op_dec.enable    = item.enable;
        cmd_known        = 1'b1;
        unique case (item.cmd)
            clrm_pkg::CMD_RESET:  op_dec.kind = clrm_pkg::OP_RESET;
            clrm_pkg::CMD_APPEND: op_dec.kind = clrm_pkg::OP_APPEND;
            clrm_pkg::CMD_DRAIN:  op_dec.kind = clrm_pkg::OP_DRAIN;
            clrm_pkg::CMD_PEEK:   op_dec.kind = clrm_pkg::OP_PEEK;
            clrm_pkg::CMD_LOCK:   op_dec.kind = clrm_pkg::OP_LOCK;
            default:
            begin
                op_dec.kind = clrm_pkg::OP_LOCK;
                cmd_known   = 1'b0;
            end
        endcase
    end

    // decoded operation queue
    clrm_queue #(
        .T     (clrm_pkg::op_item_t),
        .DEPTH (CMD_Q_DEPTH)
    ) u_op_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push && cmd_known),
        .full  (full),
        .wdata (op_dec),
        .pop   (op_pop),
        .empty (op_empty),
        .rdata (op_head)
    );

endmodule

### rtl/clrm_back.sv
// ----------------------------------------------------------------------------
// clrm_back: ring pointer engine
// Holds the configuration and the ring pointers, runs one decoded operation
// at a time and emits one result per cycle while the result queue has room,
// splitting appends and peeks at the ring wrap into two segments.
// ----------------------------------------------------------------------------
module clrm_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    input  logic [1:0]          cfg_index,
    input  logic [31:0]         cfg_data,
    input  logic                op_empty,
    input  clrm_pkg::op_item_t  op_head,
    output logic                op_pop,
    input  logic                rsp_full,
    output logic                rsp_push,
    output clrm_pkg::rsp_item_t rsp_item
);

    logic [31:0] region_base_reg, region_len_reg;
    logic [4:0]  block_shift_reg;
    logic [31:0] ring_start_reg, ring_start_next;
    logic [31:0] ring_size_reg, ring_size_next;
    logic [31:0] write_pos_reg, write_pos_next;
    logic [31:0] read_pos_reg, read_pos_next;
    logic [31:0] fill_reg, fill_next;
    logic        locked_reg, locked_next;
    logic [31:0] peek_pos_reg, peek_pos_next;
    logic [31:0] peek_left_reg, peek_left_next;
    logic        drain_busy_reg, drain_busy_next;
    logic [31:0] drain_pos_reg, drain_pos_next;
    logic [31:0] drain_left_reg, drain_left_next;
    logic [15:0] s2_reg, s2_next;

    clrm_pkg::phase_t phase_reg, phase_next;

    logic        go, first_phase, need_second, app_ok, peek_ok;
    logic [31:0] peek_pos_eff, peek_left_eff, drain_pos_eff, drain_left_eff;
    logic [31:0] len32, max32, seg_pos, avail, room, seg, adv_sum, adv_pos;
    logic [31:0] seg_addr, fill_sat, drain_rest, blk, layout_size;
    logic [15:0] s2_calc;
    logic [32:0] fill_sum;
    logic        over, too_long;

    assign go          = !op_empty && !rsp_full;
    assign first_phase = (phase_reg == clrm_pkg::PH_FIRST);
    assign len32       = {16'b0, op_head.length};
    assign max32       = {16'b0, op_head.drain_max};

    // cursor selection and segment datapath
    always_comb
    begin
        peek_pos_eff   = (op_head.first && first_phase) ? read_pos_reg : peek_pos_reg;
        peek_left_eff  = (op_head.first && first_phase) ? fill_reg : peek_left_reg;
        drain_pos_eff  = drain_busy_reg ? drain_pos_reg : read_pos_reg;
        drain_left_eff = drain_busy_reg ? drain_left_reg : fill_reg;
        unique case (op_head.kind)
            clrm_pkg::OP_APPEND:
            begin
                seg_pos = write_pos_reg;
                avail   = len32;
            end
            clrm_pkg::OP_DRAIN:
            begin
                seg_pos = drain_pos_eff;
                avail   = (drain_left_eff < max32) ? drain_left_eff : max32;
            end
            clrm_pkg::OP_PEEK:
            begin
                seg_pos = peek_pos_eff;
                avail   = (len32 < peek_left_eff) ? len32 : peek_left_eff;
            end
            default:
            begin
                seg_pos = '0;
                avail   = '0;
            end
        endcase
        room       = ring_size_reg - seg_pos;
        seg        = first_phase ? ((room < avail) ? room : avail) : {16'b0, s2_reg};
        s2_calc    = avail[15:0] - seg[15:0];
        adv_sum    = seg_pos + seg;
        adv_pos    = (adv_sum >= ring_size_reg) ? '0 : adv_sum;
        seg_addr   = region_base_reg + ring_start_reg + seg_pos;
        fill_sum   = {1'b0, fill_reg} + {1'b0, seg};
        over       = (fill_sum > {1'b0, ring_size_reg});
        fill_sat   = over ? ring_size_reg : fill_sum[31:0];
        drain_rest = drain_left_eff - seg;
        too_long   = (len32 > ring_size_reg);
        app_ok     = !op_head.len_zero && !locked_reg && !drain_busy_reg && !too_long;
        peek_ok    = !op_head.len_zero && !drain_busy_reg;
        // ring layout on reset command
        blk         = 32'd1 << block_shift_reg;
        layout_size = (region_len_reg < blk) ? '0 : ((region_len_reg - blk) & ~(blk - 32'd1));
    end

    // a wrap split needs a second segment
    always_comb
    begin
        need_second = 1'b0;
        if (first_phase && s2_calc != '0)
        begin
            if (op_head.kind == clrm_pkg::OP_APPEND)
            begin
                need_second = app_ok;
            end
            else if (op_head.kind == clrm_pkg::OP_PEEK)
            begin
                need_second = peek_ok && (avail != '0);
            end
        end
    end

    // segment phase next state
    always_comb
    begin
        phase_next = phase_reg;
        unique case (phase_reg)
            clrm_pkg::PH_FIRST:
            begin
                if (go && need_second)
                begin
                    phase_next = clrm_pkg::PH_SECOND;
                end
            end
            clrm_pkg::PH_SECOND:
            begin
                if (go)
                begin
                    phase_next = clrm_pkg::PH_FIRST;
                end
            end
            default: phase_next = clrm_pkg::PH_FIRST;
        endcase
    end

    // operation execution and result build
    always_comb
    begin
        ring_start_next = ring_start_reg;
        ring_size_next  = ring_size_reg;
        write_pos_next  = write_pos_reg;
        read_pos_next   = read_pos_reg;
        fill_next       = fill_reg;
        locked_next     = locked_reg;
        peek_pos_next   = peek_pos_reg;
        peek_left_next  = peek_left_reg;
        drain_busy_next = drain_busy_reg;
        drain_pos_next  = drain_pos_reg;
        drain_left_next = drain_left_reg;
        s2_next         = s2_reg;
        op_pop          = 1'b0;
        rsp_push        = 1'b0;
        rsp_item        = '0;
        rsp_item.last   = 1'b1;
        rsp_item.bytes_held = fill_reg;
        if (go)
        begin
            rsp_push = 1'b1;
            unique case (op_head.kind)
                clrm_pkg::OP_RESET:
                begin
                    ring_start_next     = blk;
                    ring_size_next      = layout_size;
                    write_pos_next      = '0;
                    read_pos_next       = '0;
                    fill_next           = '0;
                    locked_next         = 1'b0;
                    peek_pos_next       = '0;
                    peek_left_next      = '0;
                    drain_busy_next     = 1'b0;
                    drain_pos_next      = '0;
                    drain_left_next     = '0;
                    rsp_item.bytes_held = '0;
                    op_pop              = 1'b1;
                end
                clrm_pkg::OP_APPEND:
                begin
                    if (op_head.len_zero)
                    begin
                        rsp_item.status = clrm_pkg::STATUS_BAD_LEN;
                        op_pop          = 1'b1;
                    end
                    else if (locked_reg || drain_busy_reg)
                    begin
                        rsp_item.status = clrm_pkg::STATUS_BUSY;
                        op_pop          = 1'b1;
                    end
                    else if (too_long)
                    begin
                        rsp_item.status = clrm_pkg::STATUS_TOO_LONG;
                        op_pop          = 1'b1;
                    end
                    else
                    begin
                        rsp_item.is_write   = 1'b1;
                        rsp_item.seg_addr   = seg_addr;
                        rsp_item.seg_len    = seg[15:0];
                        rsp_item.last       = !need_second;
                        rsp_item.bytes_held = fill_sat;
                        write_pos_next      = adv_pos;
                        fill_next           = fill_sat;
                        if (need_second)
                        begin
                            s2_next = s2_calc;
                        end
                        else
                        begin
                            op_pop = 1'b1;
                            if (over)
                            begin
                                read_pos_next = adv_pos;
                            end
                        end
                    end
                end
                clrm_pkg::OP_DRAIN:
                begin
                    op_pop = 1'b1;
                    if (drain_left_eff == '0)
                    begin
                        read_pos_next       = drain_pos_eff;
                        write_pos_next      = drain_pos_eff;
                        drain_pos_next      = drain_pos_eff;
                        drain_left_next     = '0;
                        fill_next           = '0;
                        drain_busy_next     = 1'b0;
                        rsp_item.bytes_held = '0;
                    end
                    else
                    begin
                        rsp_item.seg_addr = seg_addr;
                        rsp_item.seg_len  = seg[15:0];
                        drain_pos_next    = adv_pos;
                        drain_left_next   = drain_rest;
                        if (drain_rest == '0)
                        begin
                            read_pos_next       = adv_pos;
                            write_pos_next      = adv_pos;
                            fill_next           = '0;
                            drain_busy_next     = 1'b0;
                            rsp_item.bytes_held = '0;
                        end
                        else
                        begin
                            drain_busy_next = 1'b1;
                            rsp_item.last   = 1'b0;
                        end
                    end
                end
                clrm_pkg::OP_PEEK:
                begin
                    if (op_head.len_zero)
                    begin
                        rsp_item.status = clrm_pkg::STATUS_BAD_LEN;
                        op_pop          = 1'b1;
                    end
                    else if (drain_busy_reg)
                    begin
                        rsp_item.status = clrm_pkg::STATUS_BUSY;
                        op_pop          = 1'b1;
                    end
                    else if (first_phase && avail == '0)
                    begin
                        peek_pos_next  = peek_pos_eff;
                        peek_left_next = peek_left_eff;
                        op_pop         = 1'b1;
                    end
                    else
                    begin
                        rsp_item.seg_addr = seg_addr;
                        rsp_item.seg_len  = seg[15:0];
                        rsp_item.last     = !need_second;
                        peek_pos_next     = adv_pos;
                        peek_left_next    = peek_left_eff - seg;
                        if (need_second)
                        begin
                            s2_next = s2_calc;
                        end
                        else
                        begin
                            op_pop = 1'b1;
                        end
                    end
                end
                clrm_pkg::OP_LOCK:
                begin
                    locked_next = op_head.enable;
                    op_pop      = 1'b1;
                end
                default:
                begin
                    op_pop = 1'b1;
                end
            endcase
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            region_base_reg <= clrm_pkg::REGION_BASE_RST;
            region_len_reg  <= clrm_pkg::REGION_LEN_RST;
            block_shift_reg <= clrm_pkg::BLOCK_SHIFT_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                clrm_pkg::CFG_REGION_BASE: region_base_reg <= cfg_data;
                clrm_pkg::CFG_REGION_LEN:  region_len_reg  <= cfg_data;
                clrm_pkg::CFG_BLOCK_SHIFT: block_shift_reg <= cfg_data[4:0];
                default:                   region_base_reg <= region_base_reg;
            endcase
        end
    end

    // ring state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ring_start_reg <= '0;
            ring_size_reg  <= '0;
            write_pos_reg  <= '0;
            read_pos_reg   <= '0;
            fill_reg       <= '0;
            locked_reg     <= 1'b0;
            peek_pos_reg   <= '0;
            peek_left_reg  <= '0;
            drain_busy_reg <= 1'b0;
            drain_pos_reg  <= '0;
            drain_left_reg <= '0;
            s2_reg         <= '0;
            phase_reg      <= clrm_pkg::PH_FIRST;
        end
        else
        begin
            ring_start_reg <= ring_start_next;
            ring_size_reg  <= ring_size_next;
            write_pos_reg  <= write_pos_next;
            read_pos_reg   <= read_pos_next;
            fill_reg       <= fill_next;
            locked_reg     <= locked_next;
            peek_pos_reg   <= peek_pos_next;
            peek_left_reg  <= peek_left_next;
            drain_busy_reg <= drain_busy_next;
            drain_pos_reg  <= drain_pos_next;
            drain_left_reg <= drain_left_next;
            s2_reg         <= s2_next;
            phase_reg      <= phase_next;
        end
    end

endmodule

### rtl/circular_log_ring_manager.sv
// ----------------------------------------------------------------------------
// circular_log_ring_manager: circular overwrite log pointer manager
// Turns log commands into device write and read segments of a ring that
// follows a header block inside a storage region.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter through push/full: an item is taken when push is high and
//   full is low. Unknown command codes are dropped without a result.
//   Results leave through empty/pop: the oldest result sits on result while
//   empty is low and is taken when pop is high. The user writes registers
//   through cfg_valid/cfg_ready (always ready), cfg_index and cfg_data
//   only while no request is in flight; the block does not enforce it.
// Timing:
//   A request is registered in the request queue, and its result is
//   registered in the result queue before it can be taken.
//   The engine emits one result per cycle while the result queue has room;
//   an append or peek split at the ring wrap gives two results.
//   Requests queue in front of the engine, results queue behind it, so the
//   intake keeps taking requests until the request queue fills.
// Reset:
//   rst_n clears both queues, the ring (size zero until a reset command),
//   the lock and any drain; registers return to their reset values.
//   When pop stays low, results wait and the engine stops once the result
//   queue is full; nothing is lost.
// ----------------------------------------------------------------------------
module circular_log_ring_manager #(
    parameter int CMD_Q_DEPTH = 2,
    parameter int RSP_Q_DEPTH = 2
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  clrm_pkg::req_item_t item,
    output logic                empty,
    input  logic                pop,
    output clrm_pkg::rsp_item_t result,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [31:0]         cfg_data
);

    clrm_pkg::op_item_t  op_head;
    clrm_pkg::rsp_item_t rsp_item;
    logic                op_empty, op_pop, rsp_full, rsp_push;

    assign cfg_ready = 1'b1;

    // request intake and decode
    clrm_front #(
        .CMD_Q_DEPTH (CMD_Q_DEPTH)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .item     (item),
        .op_pop   (op_pop),
        .op_empty (op_empty),
        .op_head  (op_head)
    );

    // pointer engine
    clrm_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .op_empty  (op_empty),
        .op_head   (op_head),
        .op_pop    (op_pop),
        .rsp_full  (rsp_full),
        .rsp_push  (rsp_push),
        .rsp_item  (rsp_item)
    );

    // result queue
    clrm_queue #(
        .T     (clrm_pkg::rsp_item_t),
        .DEPTH (RSP_Q_DEPTH)
    ) u_rsp_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (rsp_push),
        .full  (rsp_full),
        .wdata (rsp_item),
        .pop   (pop),
        .empty (empty),
        .rdata (result)
    );

endmodule

### rtl/clrm_checker.sv
// ----------------------------------------------------------------------------
// clrm_checker: port-level checks of the circular log ring manager
// Watches the result channel for hold behavior and consistent segment
// fields.
// ----------------------------------------------------------------------------
module clrm_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                empty,
    input logic                pop,
    input clrm_pkg::rsp_item_t result
);

    // a waiting result holds until taken
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty && $stable(result))
        else $error("result changed while waiting");

    // rejected commands carry no segment and end the command
    a_reject_plain: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && result.status != clrm_pkg::STATUS_OK |->
            result.last && result.seg_len == '0 && !result.is_write)
        else $error("rejected command carries a segment");

    // write segments come only from accepted appends and are never empty
    a_write_seg: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && result.is_write |->
            result.status == clrm_pkg::STATUS_OK && result.seg_len != '0)
        else $error("bad write segment");

endmodule

bind circular_log_ring_manager clrm_checker u_clrm_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .empty  (empty),
    .pop    (pop),
    .result (result)
);

### bench/circular_log_ring_manager_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circular_log_ring_manager_tb: self-checking bench of the log ring manager
// Drives log commands through the request queue and compares every result
// against a cycle-free predictor of the ring pointers. A directed table of
// requests comes first, then random command streams over several region
// layouts, with random idling on both sides and one long result hold-off.
// ----------------------------------------------------------------------------
module circular_log_ring_manager_tb;

    // command codes that the block drops without a result
    localparam logic [2:0] CMD_UNUSED_LO = 3'd5;
    localparam logic [2:0] CMD_UNUSED_HI = 3'd7;

    localparam int  HOLD_CYCLES   = 80;
    localparam int  TAIL_CYCLES   = 10;
    localparam int  DRAIN_LIMIT   = 20000;
    localparam time WATCHDOG_NS   = 5_000_000;

    typedef struct {
        clrm_pkg::req_item_t req;
        bit                  typed;
        clrm_pkg::rsp_item_t want;
    } plan_row_t;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                push      = 1'b0;
    logic                full;
    clrm_pkg::req_item_t item      = '0;
    logic                empty;
    logic                pop       = 1'b0;
    clrm_pkg::rsp_item_t result;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [1:0]          cfg_index = clrm_pkg::CFG_REGION_BASE;
    logic [31:0]         cfg_data  = '0;

    // register copies and ring state of the predictor
    logic [31:0] cfg_base  = clrm_pkg::REGION_BASE_RST;
    logic [31:0] cfg_len   = clrm_pkg::REGION_LEN_RST;
    logic [4:0]  cfg_shift = clrm_pkg::BLOCK_SHIFT_RST;
    logic [31:0] lay_start = '0;
    logic [31:0] lay_size  = '0;
    logic [31:0] wr_ptr    = '0;
    logic [31:0] rd_ptr    = '0;
    logic [31:0] held_bytes = '0;
    logic        lock_on   = 1'b0;
    logic        drn_busy  = 1'b0;
    logic [31:0] drn_ptr   = '0;
    logic [31:0] drn_left  = '0;
    logic [31:0] pk_ptr    = '0;
    logic [31:0] pk_left   = '0;

    clrm_pkg::rsp_item_t pending_segs[$];

    int errors       = 0;
    int results_seen = 0;
    int split_count  = 0;
    int full_waits   = 0;
    int cmd_count[8];

    // idling control shared by the two sides
    bit quiet       = 1'b0;
    bit hold_req    = 1'b0;
    bit hold_active = 1'b0;
    int stall_left  = 0;

    circular_log_ring_manager u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .empty     (empty),
        .pop       (pop),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    initial
    begin
        #(WATCHDOG_NS);
        $display("circular_log_ring_manager_tb NOT OK");
        $finish;
    end

    function automatic logic [31:0] min_u32(input logic [31:0] a, input logic [31:0] b);
        return (a < b) ? a : b;
    endfunction

    // ring offset moves on, back to zero at the end of the ring
    function automatic logic [31:0] ring_step(input logic [31:0] pos, input logic [31:0] n);
        logic [31:0] p;
        p = pos + n;
        return (p >= lay_size) ? 32'd0 : p;
    endfunction

    function automatic clrm_pkg::rsp_item_t bare_status(input logic [1:0] st,
                                                        input logic [31:0] held);
        clrm_pkg::rsp_item_t s;
        s            = '0;
        s.status     = st;
        s.last       = 1'b1;
        s.bytes_held = held;
        return s;
    endfunction

    function automatic clrm_pkg::rsp_item_t ring_seg(input logic wr, input logic [31:0] pos,
                                                     input logic [31:0] len, input logic lst,
                                                     input logic [31:0] held);
        clrm_pkg::rsp_item_t s;
        s.status     = clrm_pkg::STATUS_OK;
        s.is_write   = wr;
        s.seg_addr   = cfg_base + lay_start + pos;
        s.seg_len    = len[15:0];
        s.last       = lst;
        s.bytes_held = held;
        return s;
    endfunction

    function automatic plan_row_t plan_row(input logic [2:0] c, input logic [15:0] l,
                                           input logic f, input logic e,
                                           input bit typed, input clrm_pkg::rsp_item_t w);
        plan_row_t p;
        p.req.cmd    = c;
        p.req.length = l;
        p.req.first  = f;
        p.req.enable = e;
        p.typed      = typed;
        p.want       = w;
        return p;
    endfunction

    // log pointers after a drain ends at the drain cursor
    task automatic close_drain();
        rd_ptr     = drn_ptr;
        wr_ptr     = drn_ptr;
        held_bytes = '0;
        drn_busy   = 1'b0;
    endtask

    // segments caused by one accepted request, with the ring state update
    task automatic predict_segments(input clrm_pkg::req_item_t r, output int n,
                                    output clrm_pkg::rsp_item_t s0,
                                    output clrm_pkg::rsp_item_t s1);
        logic [31:0] len32;
        logic [31:0] part1;
        logic [31:0] part2;
        logic [31:0] held;
        logic [31:0] blk;
        logic [31:0] maxc;
        logic [31:0] chunk;
        logic [31:0] rem;
        logic [32:0] wide;
        logic        over;
        n     = 0;
        s0    = '0;
        s1    = '0;
        len32 = {16'd0, r.length};
        case (r.cmd)
            clrm_pkg::CMD_RESET:
            begin
                blk        = 32'd1 << cfg_shift;
                lay_start  = blk;
                lay_size   = (cfg_len < blk) ? 32'd0 : ((cfg_len - blk) >> cfg_shift) << cfg_shift;
                wr_ptr     = '0;
                rd_ptr     = '0;
                held_bytes = '0;
                lock_on    = 1'b0;
                drn_busy   = 1'b0;
                drn_ptr    = '0;
                drn_left   = '0;
                pk_ptr     = '0;
                pk_left    = '0;
                s0         = bare_status(clrm_pkg::STATUS_OK, 32'd0);
                n          = 1;
            end
            clrm_pkg::CMD_APPEND:
            begin
                n = 1;
                if (len32 == 0)
                begin
                    s0 = bare_status(clrm_pkg::STATUS_BAD_LEN, held_bytes);
                end
                else if (lock_on || drn_busy)
                begin
                    s0 = bare_status(clrm_pkg::STATUS_BUSY, held_bytes);
                end
                else if (len32 > lay_size)
                begin
                    s0 = bare_status(clrm_pkg::STATUS_TOO_LONG, held_bytes);
                end
                else
                begin
                    over  = ({1'b0, held_bytes} + {1'b0, len32}) > {1'b0, lay_size};
                    part1 = min_u32(lay_size - wr_ptr, len32);
                    part2 = len32 - part1;
                    wide  = {1'b0, held_bytes} + {1'b0, part1};
                    held  = (wide > {1'b0, lay_size}) ? lay_size : wide[31:0];
                    s0    = ring_seg(1'b1, wr_ptr, part1, part2 == 0, held);
                    wr_ptr = ring_step(wr_ptr, part1);
                    if (part2 != 0)
                    begin
                        wide   = {1'b0, held} + {1'b0, part2};
                        held   = (wide > {1'b0, lay_size}) ? lay_size : wide[31:0];
                        s1     = ring_seg(1'b1, wr_ptr, part2, 1'b1, held);
                        wr_ptr = ring_step(wr_ptr, part2);
                        n      = 2;
                    end
                    held_bytes = over ? lay_size : held_bytes + len32;
                    if (over)
                        rd_ptr = wr_ptr;
                end
            end
            clrm_pkg::CMD_DRAIN:
            begin
                n    = 1;
                maxc = (len32 != 0) ? len32 : {16'd0, clrm_pkg::DRAIN_DEFAULT};
                if (!drn_busy)
                begin
                    drn_busy = 1'b1;
                    drn_ptr  = rd_ptr;
                    drn_left = held_bytes;
                end
                if (drn_left == 0)
                begin
                    close_drain();
                    s0 = bare_status(clrm_pkg::STATUS_OK, 32'd0);
                end
                else
                begin
                    chunk    = min_u32(min_u32(lay_size - drn_ptr, drn_left), maxc);
                    s0       = ring_seg(1'b0, drn_ptr, chunk, 1'b0, held_bytes);
                    drn_ptr  = ring_step(drn_ptr, chunk);
                    drn_left = drn_left - chunk;
                    if (drn_left == 0)
                    begin
                        close_drain();
                        s0.last       = 1'b1;
                        s0.bytes_held = '0;
                    end
                end
            end
            clrm_pkg::CMD_PEEK:
            begin
                n = 1;
                if (len32 == 0)
                begin
                    s0 = bare_status(clrm_pkg::STATUS_BAD_LEN, held_bytes);
                end
                else if (drn_busy)
                begin
                    s0 = bare_status(clrm_pkg::STATUS_BUSY, held_bytes);
                end
                else
                begin
                    if (r.first)
                    begin
                        pk_ptr  = rd_ptr;
                        pk_left = held_bytes;
                    end
                    rem = min_u32(len32, pk_left);
                    if (rem == 0)
                    begin
                        s0 = bare_status(clrm_pkg::STATUS_OK, held_bytes);
                    end
                    else
                    begin
                        part1  = min_u32(lay_size - pk_ptr, rem);
                        part2  = rem - part1;
                        s0     = ring_seg(1'b0, pk_ptr, part1, part2 == 0, held_bytes);
                        pk_ptr = ring_step(pk_ptr, part1);
                        if (part2 != 0)
                        begin
                            s1     = ring_seg(1'b0, pk_ptr, part2, 1'b1, held_bytes);
                            pk_ptr = ring_step(pk_ptr, part2);
                            n      = 2;
                        end
                        pk_left = pk_left - rem;
                    end
                end
            end
            clrm_pkg::CMD_LOCK:
            begin
                lock_on = r.enable;
                s0      = bare_status(clrm_pkg::STATUS_OK, held_bytes);
                n       = 1;
            end
            default:
                n = 0;
        endcase
    endtask

    // offer one request, wait for it to be taken, record what it should give
    task automatic offer(input clrm_pkg::req_item_t r, input bit typed,
                         input clrm_pkg::rsp_item_t want);
        int                  n;
        clrm_pkg::rsp_item_t a;
        clrm_pkg::rsp_item_t b;
        if (!quiet && !hold_active && $urandom_range(0, 5) == 0)
        begin
            @(negedge clk);
            push <= 1'b0;
            repeat ($urandom_range(1, 12) - 1) @(negedge clk);
        end
        @(negedge clk);
        push <= 1'b1;
        item <= r;
        forever
        begin
            @(posedge clk);
            if (!full)
                break;
            full_waits++;
        end
        predict_segments(r, n, a, b);
        cmd_count[r.cmd]++;
        if (typed)
        begin
            pending_segs.push_back(want);
        end
        else
        begin
            if (n > 0)
                pending_segs.push_back(a);
            if (n > 1)
            begin
                pending_segs.push_back(b);
                split_count++;
            end
        end
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        forever
        begin
            @(posedge clk);
            if (cfg_ready)
                break;
        end
        case (idx)
            clrm_pkg::CFG_REGION_BASE: cfg_base  = val;
            clrm_pkg::CFG_REGION_LEN:  cfg_len   = val;
            clrm_pkg::CFG_BLOCK_SHIFT: cfg_shift = val[4:0];
            default: ;
        endcase
    endtask

    // stop offering and let every expected result come out
    task automatic wait_drained(input int tail);
        int guard;
        guard = 0;
        @(negedge clk);
        push <= 1'b0;
        while (pending_segs.size() != 0 && guard < DRAIN_LIMIT)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (tail) @(posedge clk);
    endtask

    function automatic logic [15:0] pick_len(input logic [31:0] span);
        logic [31:0] cap;
        int          roll;
        cap  = (span == 0) ? 32'd1 : min_u32(span, 32'd65535);
        roll = $urandom_range(0, 99);
        if (roll < 4)
            return 16'd0;
        else if (roll < 8)
            return 16'hFFFF;
        else if (roll < 16)
            return 16'($urandom_range(0, 65535));
        else
            return 16'($urandom_range(1, cap));
    endfunction

    // mostly well-formed command streams: drains run to their end, locks get lifted
    function automatic clrm_pkg::req_item_t pick_request();
        clrm_pkg::req_item_t r;
        int                  roll;
        r.first  = 1'($urandom_range(0, 1));
        r.enable = 1'($urandom_range(0, 1));
        roll     = $urandom_range(0, 99);
        if (drn_busy && roll < 85)
            r.cmd = clrm_pkg::CMD_DRAIN;
        else if (lock_on && roll < 50)
        begin
            r.cmd    = clrm_pkg::CMD_LOCK;
            r.enable = 1'b0;
        end
        else if (roll < 3)
            r.cmd = clrm_pkg::CMD_RESET;
        else if (roll < 6)
            r.cmd = 3'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
        else if (roll < 50)
            r.cmd = clrm_pkg::CMD_APPEND;
        else if (roll < 62)
            r.cmd = clrm_pkg::CMD_DRAIN;
        else if (roll < 86)
            r.cmd = clrm_pkg::CMD_PEEK;
        else
        begin
            r.cmd    = clrm_pkg::CMD_LOCK;
            r.enable = ($urandom_range(0, 3) == 0);
        end
        case (r.cmd)
            clrm_pkg::CMD_APPEND: r.length = pick_len(lay_size / 2);
            clrm_pkg::CMD_DRAIN:  r.length = pick_len(lay_size / 4);
            clrm_pkg::CMD_PEEK:   r.length = pick_len(lay_size / 2);
            default:              r.length = 16'($urandom_range(0, 65535));
        endcase
        return r;
    endfunction

    // result side: random stall bursts and one long hold-off on request
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req    = 1'b0;
                hold_active = 1'b1;
                stall_left  = HOLD_CYCLES;
            end
            if (stall_left > 0)
            begin
                pop <= 1'b0;
                stall_left--;
            end
            else
            begin
                hold_active = 1'b0;
                if (!quiet && $urandom_range(0, 6) == 0)
                begin
                    stall_left = $urandom_range(1, 12) - 1;
                    pop <= 1'b0;
                end
                else
                begin
                    pop <= 1'b1;
                end
            end
        end
    end

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            errors++;
            $display("%0t: result %0d %s mismatch: expected %0h, actual %0h",
                     $time, results_seen, name, want, got);
        end
    endtask

    // compare each taken result with the oldest expected segment
    always @(posedge clk)
    begin
        clrm_pkg::rsp_item_t want;
        if (rst_n && pop && !empty)
        begin
            results_seen++;
            if (pending_segs.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result: expected none, actual %0h",
                         $time, result);
            end
            else
            begin
                want = pending_segs.pop_front();
                check_field("status",     32'(want.status),   32'(result.status));
                check_field("is_write",   32'(want.is_write), 32'(result.is_write));
                check_field("seg_addr",   want.seg_addr,      result.seg_addr);
                check_field("seg_len",    32'(want.seg_len),  32'(result.seg_len));
                check_field("last",       32'(want.last),     32'(result.last));
                check_field("bytes_held", want.bytes_held,    result.bytes_held);
            end
        end
    end

    initial
    begin : stimulus
        plan_row_t           plan[$];
        clrm_pkg::req_item_t r;
        logic [31:0]         base;
        logic [31:0]         len;
        logic [4:0]          shift;
        int                  n_items;
        int                  done;
        bit                  relayout;
        for (int i = 0; i < 8; i++)
            cmd_count[i] = 0;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed requests on the reset layout: 4 KiB header, 60 KiB ring
        plan.push_back(plan_row(clrm_pkg::CMD_APPEND, 16'd5, 1'b0, 1'b0, 1'b1,
                                bare_status(clrm_pkg::STATUS_TOO_LONG, 32'd0)));
        plan.push_back(plan_row(clrm_pkg::CMD_DRAIN, 16'd0, 1'b0, 1'b0, 1'b1,
                                bare_status(clrm_pkg::STATUS_OK, 32'd0)));
        plan.push_back(plan_row(clrm_pkg::CMD_RESET, 16'hFFFF, 1'b1, 1'b1, 1'b1,
                                bare_status(clrm_pkg::STATUS_OK, 32'd0)));
        plan.push_back(plan_row(clrm_pkg::CMD_APPEND, 16'd0, 1'b0, 1'b0, 1'b1,
                                bare_status(clrm_pkg::STATUS_BAD_LEN, 32'd0)));
        plan.push_back(plan_row(clrm_pkg::CMD_PEEK, 16'd0, 1'b1, 1'b0, 1'b1,
                                bare_status(clrm_pkg::STATUS_BAD_LEN, 32'd0)));
        plan.push_back(plan_row(clrm_pkg::CMD_LOCK, 16'd0, 1'b0, 1'b1, 1'b1,
                                bare_status(clrm_pkg::STATUS_OK, 32'd0)));
        plan.push_back(plan_row(clrm_pkg::CMD_APPEND, 16'd100, 1'b0, 1'b0, 1'b1,
                                bare_status(clrm_pkg::STATUS_BUSY, 32'd0)));
        plan.push_back(plan_row(clrm_pkg::CMD_LOCK, 16'hFFFF, 1'b1, 1'b0, 1'b1,
                                bare_status(clrm_pkg::STATUS_OK, 32'd0)));
        plan.push_back(plan_row(clrm_pkg::CMD_APPEND, 16'hFFFF, 1'b0, 1'b0, 1'b1,
                                bare_status(clrm_pkg::STATUS_TOO_LONG, 32'd0)));
        plan.push_back(plan_row(clrm_pkg::CMD_PEEK, 16'd10, 1'b1, 1'b0, 1'b1,
                                bare_status(clrm_pkg::STATUS_OK, 32'd0)));
        // fill the ring exactly, then overflow it
        plan.push_back(plan_row(clrm_pkg::CMD_APPEND, 16'd61440, 1'b0, 1'b0, 1'b0, '0));
        plan.push_back(plan_row(clrm_pkg::CMD_APPEND, 16'd1000, 1'b0, 1'b0, 1'b0, '0));
        // peek across the wrap, then with nothing left, then a fresh snapshot
        plan.push_back(plan_row(clrm_pkg::CMD_PEEK, 16'hFFFF, 1'b1, 1'b0, 1'b0, '0));
        plan.push_back(plan_row(clrm_pkg::CMD_PEEK, 16'd10, 1'b0, 1'b0, 1'b0, '0));
        plan.push_back(plan_row(clrm_pkg::CMD_PEEK, 16'd1, 1'b1, 1'b1, 1'b0, '0));
        // drain with the default chunk, appends and peeks refused while it runs, then a lock
        plan.push_back(plan_row(clrm_pkg::CMD_DRAIN, 16'd0, 1'b0, 1'b0, 1'b0, '0));
        plan.push_back(plan_row(clrm_pkg::CMD_APPEND, 16'd50, 1'b0, 1'b0, 1'b0, '0));
        plan.push_back(plan_row(clrm_pkg::CMD_PEEK, 16'd20, 1'b1, 1'b0, 1'b0, '0));
        plan.push_back(plan_row(clrm_pkg::CMD_LOCK, 16'd0, 1'b0, 1'b1, 1'b0, '0));
        plan.push_back(plan_row(clrm_pkg::CMD_DRAIN, 16'hFFFF, 1'b0, 1'b0, 1'b0, '0));
        plan.push_back(plan_row(clrm_pkg::CMD_DRAIN, 16'hFFFF, 1'b1, 1'b1, 1'b0, '0));
        plan.push_back(plan_row(clrm_pkg::CMD_DRAIN, 16'd7, 1'b0, 1'b0, 1'b0, '0));
        // dropped codes, then a ring reset that also lifts the lock
        plan.push_back(plan_row(CMD_UNUSED_LO, 16'hFFFF, 1'b1, 1'b1, 1'b0, '0));
        plan.push_back(plan_row(CMD_UNUSED_HI, 16'h0000, 1'b0, 1'b0, 1'b0, '0));
        plan.push_back(plan_row(clrm_pkg::CMD_RESET, 16'd0, 1'b0, 1'b0, 1'b1,
                                bare_status(clrm_pkg::STATUS_OK, 32'd0)));
        plan.push_back(plan_row(clrm_pkg::CMD_APPEND, 16'd1, 1'b0, 1'b0, 1'b0, '0));
        foreach (plan[i])
            offer(plan[i].req, plan[i].typed, plan[i].want);

        // random command streams over a series of region layouts
        for (int ph = 1; ph <= 9; ph++)
        begin
            wait_drained(TAIL_CYCLES);
            relayout = 1'b1;
            n_items  = 300;
            base     = $urandom;
            case (ph)
                1:
                begin
                    shift = 5'd9;
                    len   = (32'd1 << 9) * $urandom_range(2, 9);
                end
                2:
                begin
                    base    = 32'hFFFF_FFFF;
                    len     = 32'hFFFF_FFFF;
                    shift   = 5'd16;
                    n_items = 150;
                end
                3:
                begin
                    base    = 32'd0;
                    len     = 32'd0;
                    shift   = 5'd9;
                    n_items = 60;
                end
                4:
                begin
                    len     = $urandom_range(1, 511);
                    shift   = 5'd9;
                    n_items = 40;
                end
                5:
                begin
                    len     = 32'd3 * 32'd65536 + $urandom_range(0, 65535);
                    shift   = 5'd16;
                    n_items = 200;
                end
                6:
                begin
                    // base moves under a ring laid out earlier
                    relayout = 1'b0;
                    n_items  = 120;
                end
                default:
                begin
                    shift = 5'($urandom_range(9, 12));
                    len   = (32'd1 << shift) * $urandom_range(2, 9)
                            + $urandom_range(0, (1 << shift) - 1);
                end
            endcase
            write_reg(clrm_pkg::CFG_REGION_BASE, base);
            if (relayout)
            begin
                write_reg(clrm_pkg::CFG_REGION_LEN, len);
                write_reg(clrm_pkg::CFG_BLOCK_SHIFT, {27'd0, shift});
            end
            @(negedge clk);
            cfg_valid <= 1'b0;
            if (relayout)
            begin
                r = '0;
                r.cmd = clrm_pkg::CMD_RESET;
                offer(r, 1'b0, '0);
            end
            if (ph == 1)
                hold_req = 1'b1;
            if (ph == 9)
                quiet = 1'b1;
            done = 0;
            while (done < n_items)
            begin
                r = pick_request();
                offer(r, 1'b0, '0);
                if (r.cmd <= clrm_pkg::CMD_LOCK)
                    done++;
            end
        end

        wait_drained(TAIL_CYCLES);
        if (pending_segs.size() != 0)
        begin
            errors++;
            $display("%0t: %0d expected results never arrived: expected %0h, actual none",
                     $time, pending_segs.size(), pending_segs[0]);
        end
        $display("run covered %0d appends, %0d drains, %0d peeks, %0d ring resets, %0d locks",
                 cmd_count[clrm_pkg::CMD_APPEND], cmd_count[clrm_pkg::CMD_DRAIN],
                 cmd_count[clrm_pkg::CMD_PEEK], cmd_count[clrm_pkg::CMD_RESET],
                 cmd_count[clrm_pkg::CMD_LOCK]);
        $display("%0d results checked, %0d commands split at the wrap, %0d intake stall cycles",
                 results_seen, split_count, full_waits);
        if (errors == 0)
            $display("circular_log_ring_manager_tb OK");
        else
            $display("circular_log_ring_manager_tb NOT OK");
        $finish;
    end

endmodule
